// ----- rtl/bclc_pkg.sv -----
// Shared types and constants for the bounded cycle-length counter.
// Holds sizing constants, register indexes and the control/status structs.
// No dependencies; imported by the controller, the datapath, the top level and the bench.
package bclc_pkg;

  // Sizing of the graph store, the search and the tallies.
  localparam int MaxNodes = 256;
  localparam int MaxDeg   = 16;
  localparam int MaxDepth = 16;
  localparam int CntW     = 48;

  localparam int NodeW = $clog2(MaxNodes);       // node number
  localparam int NcW   = $clog2(MaxNodes + 1);   // node count, stack pointer
  localparam int SlotW = $clog2(MaxDeg);         // slot index in a row
  localparam int DegW  = $clog2(MaxDeg + 1);     // slot counter, fill level
  localparam int FrW   = $clog2(MaxDepth);       // frame index
  localparam int DepW  = $clog2(MaxDepth + 1);   // depth, tally index

  // Register reset values.
  localparam logic [NcW-1:0]  NodeCountRst = NcW'(256);
  localparam logic [DepW-1:0] DepthRst     = DepW'(12);

  // Configuration register indexes.
  localparam logic CfgNodeCount   = 1'b0;
  localparam logic CfgSearchDepth = 1'b1;

  // Input item modes.
  localparam logic ModeAdd = 1'b0;
  localparam logic ModeRun = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add_cap;
    logic add_rd;
    logic add_wr;
    logic run_start;
    logic root_init;
    logic row_rd;
    logic scan_step;
    logic slot_clr;
    logic slot_inc;
    logic blk_rd;
    logic blk_wr;
    logic ub_init;
    logic ub_pop;
    logic ub_row;
    logic ub_load;
    logic ub_scan;
    logic frame_pop;
    logic ret_rd;
    logic ret_load;
    logic ret_rdz;
    logic ret_wr;
    logic ret_fin;
    logic emit_load;
    logic emit_ack;
    logic clear;
  } bclc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic no_roots;
    logic slot_end;
    logic live_s;
    logic push;
    logic ok;
    logic ub_empty;
    logic scan_done;
    logic sp_bottom;
    logic root_last;
    logic rt_live_s;
    logic k_last;
  } bclc_sts_t;

endpackage

// ----- rtl/bclc_ctrl.sv -----
// Controller state machine of the bounded cycle-length counter.
// Sequences edge loads, the per-root search, retirement and result output.
// Depends on bclc_pkg for the command and status structs.
module bclc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                mode_i,
  input  logic                out_ready_i,
  input  bclc_pkg::bclc_sts_t sts_i,
  output logic                in_ready_o,
  output bclc_pkg::bclc_cmd_t cmd_o
);
  import bclc_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE      = 22'h000001,
    S_ADD_RD    = 22'h000002,
    S_ADD_WR    = 22'h000004,
    S_ROOT_INIT = 22'h000008,
    S_FR_LOAD   = 22'h000010,
    S_FR_SCAN   = 22'h000020,
    S_BLK_SEL   = 22'h000040,
    S_BLK_RMW   = 22'h000080,
    S_UB_INIT   = 22'h000100,
    S_UB_POP    = 22'h000200,
    S_UB_ROW    = 22'h000400,
    S_UB_LOAD   = 22'h000800,
    S_UB_SCAN   = 22'h001000,
    S_POP       = 22'h002000,
    S_RET_RD    = 22'h004000,
    S_RET_LOAD  = 22'h008000,
    S_RET_SEL   = 22'h010000,
    S_RET_WR    = 22'h020000,
    S_RET_FIN   = 22'h040000,
    S_EMIT_LOAD = 22'h080000,
    S_EMIT_WAIT = 22'h100000,
    S_CLEAR     = 22'h200000
  } state_e;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == ModeAdd) begin
            cmd_o.add_cap = 1'b1;
            state_d       = S_ADD_RD;
          end else begin
            cmd_o.run_start = 1'b1;
            state_d         = sts_i.no_roots ? S_EMIT_LOAD : S_ROOT_INIT;
          end
        end
      end
      S_ADD_RD: begin
        cmd_o.add_rd = 1'b1;
        state_d      = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_ROOT_INIT: begin
        cmd_o.root_init = 1'b1;
        state_d         = S_FR_LOAD;
      end
      S_FR_LOAD: begin
        cmd_o.row_rd = 1'b1;
        state_d      = S_FR_SCAN;
      end
      S_FR_SCAN: begin
        if (sts_i.slot_end) begin
          if (sts_i.ok) begin
            state_d = S_UB_INIT;
          end else begin
            cmd_o.slot_clr = 1'b1;
            state_d        = S_BLK_SEL;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.push) begin
            state_d = S_FR_LOAD;
          end
        end
      end
      S_BLK_SEL: begin
        if (sts_i.slot_end) begin
          state_d = S_POP;
        end else if (sts_i.live_s) begin
          cmd_o.blk_rd = 1'b1;
          state_d      = S_BLK_RMW;
        end else begin
          cmd_o.slot_inc = 1'b1;
        end
      end
      S_BLK_RMW: begin
        cmd_o.blk_wr = 1'b1;
        state_d      = S_BLK_SEL;
      end
      S_UB_INIT: begin
        cmd_o.ub_init = 1'b1;
        state_d       = S_UB_POP;
      end
      S_UB_POP: begin
        if (sts_i.ub_empty) begin
          state_d = S_POP;
        end else begin
          cmd_o.ub_pop = 1'b1;
          state_d      = S_UB_ROW;
        end
      end
      S_UB_ROW: begin
        cmd_o.ub_row = 1'b1;
        state_d      = S_UB_LOAD;
      end
      S_UB_LOAD: begin
        cmd_o.ub_load = 1'b1;
        state_d       = S_UB_SCAN;
      end
      S_UB_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_UB_POP;
        end else begin
          cmd_o.ub_scan = 1'b1;
        end
      end
      S_POP: begin
        if (sts_i.sp_bottom) begin
          state_d = S_RET_RD;
        end else begin
          cmd_o.frame_pop = 1'b1;
          state_d         = S_FR_LOAD;
        end
      end
      S_RET_RD: begin
        cmd_o.ret_rd = 1'b1;
        state_d      = S_RET_LOAD;
      end
      S_RET_LOAD: begin
        cmd_o.ret_load = 1'b1;
        state_d        = S_RET_SEL;
      end
      S_RET_SEL: begin
        if (sts_i.slot_end) begin
          state_d = S_RET_FIN;
        end else if (sts_i.rt_live_s) begin
          cmd_o.ret_rdz = 1'b1;
          state_d       = S_RET_WR;
        end else begin
          cmd_o.slot_inc = 1'b1;
        end
      end
      S_RET_WR: begin
        cmd_o.ret_wr = 1'b1;
        state_d      = S_RET_SEL;
      end
      S_RET_FIN: begin
        cmd_o.ret_fin = 1'b1;
        state_d       = sts_i.root_last ? S_EMIT_LOAD : S_ROOT_INIT;
      end
      S_EMIT_LOAD: begin
        cmd_o.emit_load = 1'b1;
        state_d         = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_ready_i) begin
          cmd_o.emit_ack = 1'b1;
          state_d        = sts_i.k_last ? S_CLEAR : S_EMIT_LOAD;
        end
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/bclc_dp.sv -----
// Datapath of the bounded cycle-length counter: graph store, search frames,
// blocked flags, block matrix, unblock stack, tallies and the output register.
// Depends on bclc_pkg; driven by the command struct from bclc_ctrl.
module bclc_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_index_i,
  input  logic [8:0]            cfg_data_i,
  input  logic [7:0]            edge_from_i,
  input  logic [7:0]            edge_to_i,
  input  bclc_pkg::bclc_cmd_t   cmd_i,
  output bclc_pkg::bclc_sts_t   sts_o,
  output logic                  out_valid_o,
  output logic [4:0]            length_index_o,
  output logic [46:0]           cycle_count_o,
  output logic                  edge_dropped_o,
  output logic                  last_o
);
  import bclc_pkg::*;

  // Configuration registers and their effective values.
  logic [NcW-1:0]  node_cnt_q;
  logic [DepW-1:0] depth_q;
  logic [NcW-1:0]  n_eff;
  logic [DepW-1:0] depth_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_cnt_q <= NodeCountRst;
      depth_q    <= DepthRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNodeCount:   node_cnt_q <= cfg_data_i[NcW-1:0];
        CfgSearchDepth: depth_q    <= cfg_data_i[DepW-1:0];
        default:        node_cnt_q <= node_cnt_q;
      endcase
    end
  end

  assign n_eff = (node_cnt_q > NcW'(MaxNodes)) ? NcW'(MaxNodes) : node_cnt_q;

  always_comb begin
    if (depth_q < DepW'(2)) begin
      depth_eff = DepW'(2);
    end else if (depth_q > DepW'(MaxDepth)) begin
      depth_eff = DepW'(MaxDepth);
    end else begin
      depth_eff = depth_q;
    end
  end

  // Graph store: slot rows, live masks and fill levels, one row per node.
  logic [MaxDeg-1:0][NodeW-1:0] tab_mem  [MaxNodes];
  logic [MaxDeg-1:0]            live_mem [MaxNodes];
  logic [DegW-1:0]              fill_mem [MaxNodes];
  logic [MaxNodes-1:0]          live_vld_q, fill_vld_q;

  logic [MaxDeg-1:0][NodeW-1:0] tab_rd_q;
  logic [MaxDeg-1:0]            live_rd_q;
  logic [DegW-1:0]              fill_rd_q;
  logic                         live_rv_q, fill_rv_q;

  logic [MaxDeg-1:0] live_row;
  logic [DegW-1:0]   fill_cur;

  // Search state: current frame, saved frames, root and unblock registers.
  logic [NodeW-1:0] a_q, b_q;
  logic [NodeW-1:0] root_q, v_q;
  logic [DegW-1:0]  s_q;
  logic             ok_q;
  logic [DepW-1:0]  sp_q, sp_m1, sp_m2;
  logic [NodeW-1:0] frm_node_q [MaxDepth];
  logic [DegW-1:0]  frm_slot_q [MaxDepth];
  logic             frm_ok_q   [MaxDepth];

  logic [MaxDeg-1:0]            rt_live_q;
  logic [MaxDeg-1:0][NodeW-1:0] rt_tab_q;

  logic [MaxNodes-1:0] blocked_q;

  logic [MaxNodes-1:0] blk_mem [MaxNodes];
  logic [MaxNodes-1:0] blk_vld_q;
  logic [MaxNodes-1:0] blk_rd_q;
  logic                blk_rv_q;
  logic [MaxNodes-1:0] blk_row;

  logic [NodeW-1:0] ustk_mem [MaxNodes];
  logic [NodeW-1:0] ustk_rd_q;
  logic [NcW-1:0]   usp_q, usp_m1;
  logic [MaxNodes-1:0] scan_q;
  logic [NodeW-1:0] ubw_q;
  logic             ub_hit;

  logic [CntW-1:0]  tally_q [MaxDepth+1];
  logic [DepW-1:0]  tsel;
  logic [CntW-1:0]  tally_sel;
  logic [DepW-1:0]  k_q;
  logic             dropped_q;

  logic             out_vld_q;
  logic [DepW-1:0]  len_q;
  logic [CntW-2:0]  cnt_q;
  logic             drop_q, last_q;

  // Slot decode of the current frame row.
  logic [NodeW-1:0] w_s, z_s;
  logic             live_s, hit_root, w_free, can_push, push, deep_ok;
  logic             add_ok;
  logic [MaxDeg-1:0] match;

  assign live_row = live_rv_q ? live_rd_q : '0;
  assign fill_cur = fill_rv_q ? fill_rd_q : '0;
  assign blk_row  = blk_rv_q ? blk_rd_q : '0;
  assign w_s      = tab_rd_q[s_q[SlotW-1:0]];
  assign z_s      = rt_tab_q[s_q[SlotW-1:0]];
  assign live_s   = live_row[s_q[SlotW-1:0]];
  assign hit_root = live_s && (w_s == root_q);
  assign w_free   = live_s && (w_s != root_q) && !blocked_q[w_s];
  assign can_push = (sp_q < depth_eff);
  assign push     = w_free && can_push;
  assign deep_ok  = w_free && !can_push;
  assign sp_m1    = sp_q - DepW'(1);
  assign sp_m2    = sp_q - DepW'(2);
  assign usp_m1   = usp_q - NcW'(1);
  assign ub_hit   = scan_q[0] && blocked_q[ubw_q];

  assign add_ok = ({1'b0, a_q} < n_eff) && ({1'b0, b_q} < n_eff) &&
                  (fill_cur < DegW'(MaxDeg));

  // Slots of a neighbour row that point back at the current root.
  always_comb begin
    for (int t = 0; t < MaxDeg; t++) begin
      match[t] = (tab_rd_q[t] == root_q);
    end
  end

  // Row read port address, shared by search, retirement and edge loads.
  logic [NodeW-1:0] row_addr;
  logic             row_en;

  always_comb begin
    row_en = cmd_i.row_rd | cmd_i.ret_rd | cmd_i.ret_rdz | cmd_i.add_rd;
    priority if (cmd_i.row_rd) begin
      row_addr = v_q;
    end else if (cmd_i.ret_rd) begin
      row_addr = root_q;
    end else if (cmd_i.ret_rdz) begin
      row_addr = z_s;
    end else begin
      row_addr = a_q;
    end
  end

  // Live row write port: edge loads set a bit, retirement clears bits.
  logic              lw_en;
  logic [NodeW-1:0]  lw_addr;
  logic [MaxDeg-1:0] lw_data;

  always_comb begin
    lw_en   = (cmd_i.add_wr && add_ok) || cmd_i.ret_wr;
    lw_addr = cmd_i.add_wr ? a_q : z_s;
    lw_data = cmd_i.add_wr ? (live_row | (MaxDeg'(1) << fill_cur[SlotW-1:0]))
                           : (live_row & ~match);
  end

  // Graph store memories.
  always_ff @(posedge clk_i) begin
    if (row_en) begin
      tab_rd_q  <= tab_mem[row_addr];
      live_rd_q <= live_mem[row_addr];
      fill_rd_q <= fill_mem[row_addr];
    end
    if (cmd_i.add_wr && add_ok) begin
      tab_mem[a_q][fill_cur[SlotW-1:0]] <= b_q;
      fill_mem[a_q] <= fill_cur + DegW'(1);
    end
    if (lw_en) begin
      live_mem[lw_addr] <= lw_data;
    end
  end

  // Row valid flags of the graph store; an invalid row reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_vld_q <= '0;
      fill_vld_q <= '0;
      live_rv_q  <= 1'b0;
      fill_rv_q  <= 1'b0;
    end else if (cmd_i.clear) begin
      live_vld_q <= '0;
      fill_vld_q <= '0;
    end else begin
      if (row_en) begin
        live_rv_q <= live_vld_q[row_addr];
        fill_rv_q <= fill_vld_q[row_addr];
      end
      if (lw_en) begin
        live_vld_q[lw_addr] <= 1'b1;
      end
      if (cmd_i.add_wr && add_ok) begin
        fill_vld_q[a_q] <= 1'b1;
      end
      if (cmd_i.ret_fin) begin
        live_vld_q[root_q] <= 1'b0;
      end
    end
  end

  // Block matrix: read-modify-write of one row per blocking edge.
  logic [NodeW-1:0] blk_addr;
  assign blk_addr = cmd_i.blk_rd ? w_s : ustk_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.blk_rd || cmd_i.ub_row) begin
      blk_rd_q <= blk_mem[blk_addr];
    end
    if (cmd_i.blk_wr) begin
      blk_mem[w_s] <= blk_row | (MaxNodes'(1) << v_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_vld_q <= '0;
      blk_rv_q  <= 1'b0;
    end else if (cmd_i.clear) begin
      blk_vld_q <= '0;
    end else begin
      if (cmd_i.blk_rd || cmd_i.ub_row) begin
        blk_rv_q <= blk_vld_q[blk_addr];
      end
      if (cmd_i.blk_wr) begin
        blk_vld_q[w_s] <= 1'b1;
      end
      if (cmd_i.ub_load) begin
        blk_vld_q[ustk_rd_q] <= 1'b0;
      end
    end
  end

  // Blocked flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_q <= '0;
    end else if (cmd_i.clear) begin
      blocked_q <= '0;
    end else begin
      if (cmd_i.root_init) begin
        blocked_q[root_q] <= 1'b1;
      end
      if (cmd_i.scan_step && push) begin
        blocked_q[w_s] <= 1'b1;
      end
      if (cmd_i.ub_init) begin
        blocked_q[v_q] <= 1'b0;
      end
      if (cmd_i.ub_scan && ub_hit) begin
        blocked_q[ubw_q] <= 1'b0;
      end
    end
  end

  // Unblock stack memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ub_init) begin
      ustk_mem[0] <= v_q;
    end
    if (cmd_i.ub_scan && ub_hit) begin
      ustk_mem[usp_q[NodeW-1:0]] <= ubw_q;
    end
    if (cmd_i.ub_pop) begin
      ustk_rd_q <= ustk_mem[usp_m1[NodeW-1:0]];
    end
  end

  // Unblock pointer and the bit scan over one block-matrix row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usp_q  <= '0;
      scan_q <= '0;
      ubw_q  <= '0;
    end else begin
      if (cmd_i.ub_init) begin
        usp_q <= NcW'(1);
      end else if (cmd_i.ub_pop) begin
        usp_q <= usp_m1;
      end else if (cmd_i.ub_scan && ub_hit) begin
        usp_q <= usp_q + NcW'(1);
      end
      if (cmd_i.ub_load) begin
        scan_q <= blk_row;
        ubw_q  <= '0;
      end else if (cmd_i.ub_scan) begin
        scan_q <= scan_q >> 1;
        ubw_q  <= ubw_q + NodeW'(1);
      end
    end
  end

  // Saved search frames, written on a push and read back on a pop.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && push) begin
      frm_node_q[sp_m1[FrW-1:0]] <= v_q;
      frm_slot_q[sp_m1[FrW-1:0]] <= s_q + DegW'(1);
      frm_ok_q[sp_m1[FrW-1:0]]   <= ok_q;
    end
  end

  // Current frame, slot counter, root and result counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      root_q <= '0;
      v_q    <= '0;
      s_q    <= '0;
      ok_q   <= 1'b0;
      sp_q   <= '0;
      k_q    <= '0;
      rt_live_q <= '0;
      rt_tab_q  <= '0;
    end else begin
      if (cmd_i.add_cap) begin
        a_q <= edge_from_i;
        b_q <= edge_to_i;
      end
      if (cmd_i.run_start) begin
        root_q <= '0;
        k_q    <= '0;
      end
      if (cmd_i.ret_fin) begin
        root_q <= root_q + NodeW'(1);
      end
      if (cmd_i.emit_ack) begin
        k_q <= k_q + DepW'(1);
      end
      if (cmd_i.root_init) begin
        v_q  <= root_q;
        s_q  <= '0;
        ok_q <= 1'b0;
        sp_q <= DepW'(1);
      end
      if (cmd_i.scan_step) begin
        if (push) begin
          v_q  <= w_s;
          s_q  <= '0;
          ok_q <= 1'b0;
          sp_q <= sp_q + DepW'(1);
        end else begin
          s_q  <= s_q + DegW'(1);
          ok_q <= ok_q | hit_root | deep_ok;
        end
      end
      if (cmd_i.slot_clr || cmd_i.ret_load) begin
        s_q <= '0;
      end
      if (cmd_i.slot_inc || cmd_i.blk_wr || cmd_i.ret_wr) begin
        s_q <= s_q + DegW'(1);
      end
      if (cmd_i.frame_pop) begin
        v_q  <= frm_node_q[sp_m2[FrW-1:0]];
        s_q  <= frm_slot_q[sp_m2[FrW-1:0]];
        ok_q <= frm_ok_q[sp_m2[FrW-1:0]] | ok_q;
        sp_q <= sp_m1;
      end
      if (cmd_i.ret_load) begin
        rt_live_q <= live_row;
        rt_tab_q  <= tab_rd_q;
      end
      // A self loop on the root also clears slots of the row being walked.
      if (cmd_i.ret_wr && (z_s == root_q)) begin
        rt_live_q <= rt_live_q & ~match;
      end
    end
  end

  // Saturating tallies; entry zero counts every edge examined.
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] x);
    sat_inc = (x == {CntW{1'b1}}) ? x : x + CntW'(1);
  endfunction

  assign tsel      = cmd_i.emit_load ? k_q : sp_q;
  assign tally_sel = tally_q[tsel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= MaxDepth; i++) begin
        tally_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i <= MaxDepth; i++) begin
        tally_q[i] <= '0;
      end
    end else if (cmd_i.scan_step && live_s) begin
      tally_q[0] <= sat_inc(tally_q[0]);
      if (hit_root) begin
        tally_q[sp_q] <= sat_inc(tally_sel);
      end
    end
  end

  // Dropped-edge flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dropped_q <= 1'b0;
    end else if (cmd_i.clear) begin
      dropped_q <= 1'b0;
    end else if (cmd_i.add_wr && !add_ok) begin
      dropped_q <= 1'b1;
    end
  end

  // Output register; lengths one and two always report zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_vld_q <= 1'b1;
    end else if (cmd_i.emit_ack) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      len_q  <= k_q;
      cnt_q  <= ((k_q == DepW'(1)) || (k_q == DepW'(2))) ? '0 : tally_sel[CntW-1:1];
      drop_q <= dropped_q;
      last_q <= (k_q == depth_eff);
    end
  end

  assign out_valid_o    = out_vld_q;
  assign length_index_o = len_q;
  assign cycle_count_o  = cnt_q;
  assign edge_dropped_o = drop_q;
  assign last_o         = last_q;

  // Status to the controller.
  always_comb begin
    sts_o           = '0;
    sts_o.no_roots  = (n_eff == '0);
    sts_o.slot_end  = (s_q == DegW'(MaxDeg));
    sts_o.live_s    = live_s;
    sts_o.push      = push;
    sts_o.ok        = ok_q;
    sts_o.ub_empty  = (usp_q == '0);
    sts_o.scan_done = (scan_q == '0);
    sts_o.sp_bottom = (sp_q == DepW'(1));
    sts_o.root_last = ((NcW'(root_q) + NcW'(1)) == n_eff);
    sts_o.rt_live_s = rt_live_q[s_q[SlotW-1:0]];
    sts_o.k_last    = (k_q == depth_eff);
  end

endmodule

// ----- rtl/bounded_cycle_length_counter_top.sv -----
// Top level of the bounded cycle-length counter.
// Instantiates the controller (bclc_ctrl) and the datapath (bclc_dp).
// Depends on bclc_pkg.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_ready_o    mode_i, edge_from_i, edge_to_i
//   out      source     out_valid_o / out_ready_i  length_index_o, cycle_count_o,
//                                                  edge_dropped_o, last_o
//   cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An edge load runs through capture, row read and row write.
// Each frame visit of a run reads the row, scans it slot by slot and then decides.
// A dead end then walks the row again slot by slot, with a read-modify-write per live
// slot, plus an end step and a pop. An unblock starts the stack and then, per node
// released, pops it, reads and loads its block-matrix row and scans each bit up to and
// including the highest set bit. Retiring a root reads and loads its row, walks each
// slot and rewrites the row behind each live slot; each result is held until taken.
// Reset clears all state at once through row valid flags; there is no clearing pass.
// A stalled result holds the block; no new item is taken until the last one leaves.
module bounded_cycle_length_counter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  edge_from_i,
  input  logic [7:0]  edge_to_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  length_index_o,
  output logic [46:0] cycle_count_o,
  output logic        edge_dropped_o,
  output logic        last_o
);
  import bclc_pkg::*;

  bclc_cmd_t cmd;
  bclc_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  bclc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  bclc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .edge_from_i    (edge_from_i),
    .edge_to_i      (edge_to_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .length_index_o (length_index_o),
    .cycle_count_o  (cycle_count_o),
    .edge_dropped_o (edge_dropped_o),
    .last_o         (last_o)
  );

endmodule

// ----- rtl/bclc_checker.sv -----
// Port-level checker for the bounded cycle-length counter.
// Watches only the top-level ports; attached by the bind statement below.
// No package dependencies.
module bclc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  length_index_o,
  input logic [46:0] cycle_count_o,
  input logic        edge_dropped_o,
  input logic        last_o
);

  // The block never takes an item while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(length_index_o) && $stable(cycle_count_o) &&
       $stable(edge_dropped_o) && $stable(last_o)))
    else $error("result changed while stalled");

  // Lengths one and two always report zero.
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (length_index_o == 5'd1 || length_index_o == 5'd2)) |->
      (cycle_count_o == '0))
    else $error("nonzero count for length one or two");

  // The final result carries at least length two; after it leaves, the block
  // passes through its clear state and then becomes ready again.
  a_last_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (length_index_o >= 5'd2))
    else $error("final result below the minimum depth");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> (!in_ready_o ##1 in_ready_o))
    else $error("block not idle after the final result");

endmodule

bind bounded_cycle_length_counter_top bclc_checker u_bclc_checker (.*);

// ----- test/tb_bounded_cycle_length_counter_top.sv -----
// Self-checking testbench for the bounded cycle-length counter top level.
// Loads edges, runs depth-limited cycle searches and checks every count
// against a predictor kept inside the bench. Depends on bclc_pkg.
module tb_bounded_cycle_length_counter_top;
  import bclc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemGoal   = 380;
  localparam int QuietCyc   = 12;
  localparam int LongHold   = 400;
  localparam longint TallyTop = (64'd1 << 48) - 1;

  typedef enum logic [1:0] {StepEdge, StepRun, StepCfg, StepDrain} step_kind_e;

  typedef struct {
    step_kind_e  kind;
    logic        cfg_idx;
    logic [8:0]  cfg_val;
    logic [7:0]  src;
    logic [7:0]  dst;
  } step_t;

  typedef struct {
    logic [4:0]  length;
    logic [46:0] count;
    logic        dropped;
    logic        last;
  } count_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [8:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = 1'b0;
  logic [7:0]  edge_from_i = '0;
  logic [7:0]  edge_to_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [4:0]  length_index_o;
  logic [46:0] cycle_count_o;
  logic        edge_dropped_o;
  logic        last_o;

  step_t  pending_steps[$];
  count_t expected_counts[$];
  int     mismatches = 0;

  // Predictor copy of the graph store, search state and tallies.
  logic [7:0]   adj_dst[4096];
  bit           adj_live[4096];
  int           adj_fill[256];
  bit           node_blocked[256];
  bit [255:0]   blocker_rows[256];
  int           frame_node[17];
  int           frame_slot[17];
  bit           frame_ok[17];
  int           release_stack[257];
  longint       length_tally[17];
  bit           any_dropped;
  int           node_limit;
  int           depth_limit;

  bounded_cycle_length_counter_top u_dut (.*);

  // Clock with a 12 ns period.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic void wipe_graph();
    for (int i = 0; i < 4096; i++) adj_live[i] = 1'b0;
    for (int i = 0; i < 256; i++) begin
      adj_fill[i] = 0;
      node_blocked[i] = 1'b0;
      blocker_rows[i] = '0;
    end
    for (int i = 0; i < 17; i++) length_tally[i] = 0;
    any_dropped = 1'b0;
  endfunction

  function automatic int active_nodes();
    return (node_limit > MaxNodes) ? MaxNodes : node_limit;
  endfunction

  function automatic void bump_tally(int idx);
    if (length_tally[idx] < TallyTop) length_tally[idx]++;
  endfunction

  function automatic void load_edge(int src, int dst);
    int n;
    n = active_nodes();
    if (src >= n || dst >= n || adj_fill[src] >= MaxDeg) begin
      any_dropped = 1'b1;
    end else begin
      adj_dst[src*MaxDeg + adj_fill[src]] = dst[7:0];
      adj_live[src*MaxDeg + adj_fill[src]] = 1'b1;
      adj_fill[src]++;
    end
  endfunction

  // Unblock a node and, transitively, every node recorded in its row.
  function automatic void release_node(int u);
    int sp;
    int x;
    sp = 0;
    node_blocked[u] = 1'b0;
    release_stack[sp++] = u;
    while (sp > 0) begin
      x = release_stack[--sp];
      for (int w = 0; w < MaxNodes; w++) begin
        if (blocker_rows[x][w]) begin
          blocker_rows[x][w] = 1'b0;
          if (node_blocked[w] && sp < MaxNodes + 1) begin
            node_blocked[w] = 1'b0;
            release_stack[sp++] = w;
          end
        end
      end
    end
  endfunction

  // Depth-limited blocked search from one root.
  function automatic void explore_from_root(int root, int depth);
    int sp, v, fill, s, w, idx;
    bit pushed, ok;
    sp = 1;
    frame_node[0] = root;
    frame_slot[0] = 0;
    frame_ok[0] = 1'b0;
    node_blocked[root] = 1'b1;
    while (sp > 0) begin
      v = frame_node[sp-1];
      fill = adj_fill[v];
      s = frame_slot[sp-1];
      pushed = 1'b0;
      while (s < fill && s < MaxDeg) begin
        idx = v*MaxDeg + s;
        s++;
        if (!adj_live[idx]) continue;
        w = adj_dst[idx];
        bump_tally(0);
        if (w == root) begin
          bump_tally(sp);
          frame_ok[sp-1] = 1'b1;
        end else if (!node_blocked[w]) begin
          if (sp < depth) begin
            frame_slot[sp-1] = s;
            frame_node[sp] = w;
            frame_slot[sp] = 0;
            frame_ok[sp] = 1'b0;
            node_blocked[w] = 1'b1;
            sp++;
            pushed = 1'b1;
            break;
          end
          frame_ok[sp-1] = 1'b1;
        end
      end
      if (pushed) continue;
      ok = frame_ok[sp-1];
      if (ok) begin
        release_node(v);
      end else begin
        for (int t = 0; t < fill && t < MaxDeg; t++) begin
          if (adj_live[v*MaxDeg + t]) blocker_rows[adj_dst[v*MaxDeg + t]][v] = 1'b1;
        end
      end
      sp--;
      if (sp > 0 && ok) frame_ok[sp-1] = 1'b1;
    end
  endfunction

  // Remove every edge out of a finished root and every edge into it from one of its successors.
  function automatic void drop_root_edges(int r);
    int z;
    for (int s = 0; s < adj_fill[r] && s < MaxDeg; s++) begin
      if (!adj_live[r*MaxDeg + s]) continue;
      z = adj_dst[r*MaxDeg + s];
      for (int t = 0; t < adj_fill[z] && t < MaxDeg; t++) begin
        if (adj_live[z*MaxDeg + t] && adj_dst[z*MaxDeg + t] == r)
          adj_live[z*MaxDeg + t] = 1'b0;
      end
    end
    for (int s = 0; s < MaxDeg; s++) adj_live[r*MaxDeg + s] = 1'b0;
  endfunction

  // Full search over all roots, then queue one count per length.
  function automatic void count_cycles_run();
    int depth;
    count_t c;
    depth = depth_limit;
    if (depth < 2) depth = 2;
    if (depth > MaxDepth) depth = MaxDepth;
    for (int r = 0; r < active_nodes(); r++) begin
      explore_from_root(r, depth);
      drop_root_edges(r);
    end
    length_tally[1] = 0;
    length_tally[2] = 0;
    for (int k = 0; k <= depth; k++) begin
      c.length  = k[4:0];
      c.count   = length_tally[k][47:1];
      c.dropped = any_dropped;
      c.last    = (k == depth);
      expected_counts = {expected_counts, c};
    end
    wipe_graph();
  endfunction

  function automatic void queue_edge(int src, int dst);
    step_t st;
    st = '{kind: StepEdge, cfg_idx: 1'b0, cfg_val: '0, src: src[7:0], dst: dst[7:0]};
    pending_steps = {pending_steps, st};
  endfunction

  function automatic void queue_run();
    step_t st;
    st = '{kind: StepRun, cfg_idx: 1'b0, cfg_val: '0,
           src: 8'($urandom_range(0, 255)), dst: 8'($urandom_range(0, 255))};
    pending_steps = {pending_steps, st};
  endfunction

  function automatic void queue_cfg(logic idx, int val);
    step_t st;
    st = '{kind: StepCfg, cfg_idx: idx, cfg_val: val[8:0], src: '0, dst: '0};
    pending_steps = {pending_steps, st};
  endfunction

  function automatic void queue_drain();
    step_t st;
    st = '{kind: StepDrain, cfg_idx: 1'b0, cfg_val: '0, src: '0, dst: '0};
    pending_steps = {pending_steps, st};
  endfunction

  // Sender: offers edge and run transactions and register writes.
  int  send_gap = 0;
  int  send_calm = 0;
  bit  send_busy = 1'b0;
  int  quiet_cycles = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic  next_in_v;
    logic  next_cfg_v;
    step_t head;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      next_in_v  = in_valid_i;
      next_cfg_v = cfg_valid_i;
      if (in_valid_i && in_ready_o) begin
        if (mode_i == ModeAdd) load_edge(edge_from_i, edge_to_i);
        else count_cycles_run();
        next_in_v = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgNodeCount) node_limit = cfg_data_i;
        else depth_limit = cfg_data_i[4:0];
        next_cfg_v = 1'b0;
      end
      if (!next_in_v && !next_cfg_v && expected_counts.size() == 0) quiet_cycles++;
      else quiet_cycles = 0;
      if (!next_in_v && !next_cfg_v) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_steps.size() > 0) begin
          head = pending_steps[0];
          case (head.kind)
            StepCfg: begin
              if (quiet_cycles >= QuietCyc) begin
                cfg_index_i <= head.cfg_idx;
                cfg_data_i  <= head.cfg_val;
                next_cfg_v = 1'b1;
                void'(pending_steps.pop_front());
              end
            end
            StepDrain: begin
              if (quiet_cycles >= QuietCyc) void'(pending_steps.pop_front());
            end
            default: begin
              mode_i      <= (head.kind == StepRun) ? ModeRun : ModeAdd;
              edge_from_i <= head.src;
              edge_to_i   <= head.dst;
              next_in_v = 1'b1;
              void'(pending_steps.pop_front());
              // Alternate calm stretches with stretches of random gaps.
              if (send_calm == 0) send_calm = $urandom_range(10, 40);
              send_calm--;
              send_busy = (send_calm == 0) ? ($urandom_range(0, 1) == 1) : send_busy;
              send_gap = send_busy ? $urandom_range(0, 18) : 0;
            end
          endcase
        end
      end
      in_valid_i  <= next_in_v;
      cfg_valid_i <= next_cfg_v;
    end
  end

  // Receiver: checks each count transaction and stalls at random.
  int  recv_wait = 0;
  int  recv_calm = 0;
  bit  recv_busy = 1'b1;
  int  counts_seen = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic   next_rdy;
    count_t exp_c;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      next_rdy = out_ready_i;
      if (out_valid_o && out_ready_i) begin
        counts_seen++;
        if (expected_counts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected count: length %0d count %0d",
                     length_index_o, cycle_count_o);
        end else begin
          exp_c = expected_counts.pop_front();
          if (length_index_o !== exp_c.length || cycle_count_o !== exp_c.count ||
              edge_dropped_o !== exp_c.dropped || last_o !== exp_c.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"count mismatch: exp len %0d cnt %0d drop %0b last %0b, ",
                        "got len %0d cnt %0d drop %0b last %0b"},
                       exp_c.length, exp_c.count, exp_c.dropped, exp_c.last,
                       length_index_o, cycle_count_o, edge_dropped_o, last_o);
          end
        end
        if (recv_calm == 0) begin
          recv_calm = $urandom_range(10, 40);
          recv_busy = ($urandom_range(0, 2) != 0);
        end
        recv_calm--;
        recv_wait = recv_busy ? $urandom_range(0, 18) : 0;
        // One long hold-off so the block backs up into its input.
        if (counts_seen == 30) recv_wait = LongHold;
        next_rdy = (recv_wait == 0);
      end else if (!out_ready_i) begin
        if (recv_wait > 0) recv_wait--;
        else next_rdy = 1'b1;
      end
      out_ready_i <= next_rdy;
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin
    int items;
    int n_plan;
    int k;
    int pick;
    node_limit  = 256;
    depth_limit = 12;
    wipe_graph();

    // Directed: a pair of opposed edges, self loop, triangle and top node ids.
    queue_edge(0, 1); queue_edge(1, 0); queue_edge(0, 0); queue_edge(1, 2);
    queue_edge(2, 0); queue_edge(255, 255); queue_edge(254, 253); queue_edge(253, 254);
    queue_run();
    // Smallest depth, endpoints out of range.
    queue_cfg(CfgNodeCount, 3); queue_cfg(CfgSearchDepth, 2);
    queue_edge(0, 1); queue_edge(1, 2); queue_edge(2, 0); queue_edge(5, 0); queue_edge(0, 7);
    queue_run();
    // No nodes at all.
    queue_cfg(CfgNodeCount, 0);
    queue_edge(0, 0); queue_run();
    // One node with a self loop, depth below range.
    queue_cfg(CfgNodeCount, 1); queue_cfg(CfgSearchDepth, 0);
    queue_edge(0, 0); queue_run();
    // Node count lowered after loading, depth above range.
    queue_cfg(CfgNodeCount, 4); queue_cfg(CfgSearchDepth, 31);
    queue_edge(0, 1); queue_edge(1, 2); queue_edge(2, 3); queue_edge(3, 0);
    queue_cfg(CfgNodeCount, 2);
    queue_run();
    queue_cfg(CfgNodeCount, 511); queue_cfg(CfgSearchDepth, 16);
    queue_edge(9, 9); queue_run();
    items = 26;
    n_plan = 256;

    // Random phases: at times new register values, then a batch of edges followed by a run.
    while (items < ItemGoal) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) n_plan = 0;
        else if (pick == 1) n_plan = 256;
        else if (pick == 2) n_plan = $urandom_range(257, 511);
        else if (pick == 3) n_plan = $urandom_range(0, 511);
        else n_plan = $urandom_range(1, 12);
        queue_cfg(CfgNodeCount, n_plan);
        queue_cfg(CfgSearchDepth,
                  ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511) : $urandom_range(2, 16));
      end
      if (items > 60 && items < 80) queue_drain();
      k = $urandom_range(0, 30);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 7) == 0 || n_plan == 0)
          queue_edge($urandom_range(0, 255), $urandom_range(0, 255));
        else
          queue_edge($urandom_range(0, (n_plan > 256 ? 256 : n_plan) - 1),
                     $urandom_range(0, (n_plan > 256 ? 256 : n_plan) - 1));
      end
      queue_run();
      items += k + 1;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_steps.size() > 0 || in_valid_i || cfg_valid_i ||
           expected_counts.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_counts.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(6_000_000 * 12);
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bclc_pkg.sv
rtl/bclc_ctrl.sv
rtl/bclc_dp.sv
rtl/bounded_cycle_length_counter_top.sv
rtl/bclc_checker.sv
test/tb_bounded_cycle_length_counter_top.sv
